// ----- rtl/dtor_pkg.sv -----
// Package: request/result types, codes and constants for the divider timer block.
`timescale 1ns / 1ps
package dtor_pkg;

    localparam int MAX_TICK_CYCLES = 15;
    localparam int TICK_W          = 4;
    localparam int CYC_W           = $clog2(MAX_TICK_CYCLES + 1);
    localparam int CMP_W           = (CYC_W > TICK_W) ? CYC_W : TICK_W;
    localparam int STEP_W          = CYC_W + 2;

    localparam logic [15:0] DIV_RESET       = 16'hABCC;
    localparam logic [7:0]  CTRL_READ_MASK  = 8'hF8;
    localparam logic [2:0]  RELOAD_DELAY    = 3'd4;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        REG_DIV  = 2'd0,
        REG_TIMA = 2'd1,
        REG_TMA  = 2'd2,
        REG_TAC  = 2'd3
    } t_reg;

    typedef struct packed {
        t_func              func;
        t_reg               reg_select;
        logic [7:0]         write_data;
        logic [TICK_W-1:0]  tick_count;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_RUN     = 2'd1,
        ST_ACT     = 2'd2,
        ST_DELIVER = 2'd3
    } t_state;

    typedef struct packed {
        logic capture;
        logic step;
        logic act;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic steps_zero;
    } t_dp_status;

    // Divider bit watched for each timer clock select
    function automatic logic [3:0] sel_bit(input logic [1:0] sel);
        logic [3:0] b;
        unique case (sel)
            2'd0:    b = 4'd9;
            2'd1:    b = 4'd3;
            2'd2:    b = 4'd5;
            default: b = 4'd7;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/divider_timer_overflow_reload_top.sv -----
// Top level: divider timer with overflow reload, controller plus datapath.
//
// Request channel (i_in_valid / o_in_stall / i_in) carries a tick, a register
// read or a register write. Result channel (o_out_valid / i_out_stall / o_out)
// returns one result per request: read byte and timer interrupt flag.
// A request is taken only while the block is idle. A tick of N machine cycles
// runs 4*N clock steps, one per cycle (N saturates at MAX_TICK_CYCLES); reads,
// writes and zero ticks run no steps. After the steps the register action
// runs, then the result register is loaded, and the block is idle again in
// the cycle after the load, so a new request is taken only once the last
// one's result is loaded.
// The result sits in an output register; if the receiver stalls and a result
// is still waiting, the next one is held in the datapath until the slot frees,
// and no new request is taken meanwhile.
// Synchronous reset sets the divider to 0xABCC, clears the timer count,
// reload value, control, gated bit, reload delay, reload flag and result valid.
`timescale 1ns / 1ps
module divider_timer_overflow_reload_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  dtor_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output dtor_pkg::t_out  o_out
);
    import dtor_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    dtor_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    dtor_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_in),
        .i_cmd    (cmd),
        .o_status (status),
        .o_out    (o_out)
    );

endmodule

// ----- rtl/dtor_ctrl.sv -----
// Controller: sequences capture, clock steps, register action and result delivery.
`timescale 1ns / 1ps
module dtor_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output dtor_pkg::t_dp_cmd     o_cmd,
    input  dtor_pkg::t_dp_status  i_status
);
    import dtor_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_status.steps_zero) begin
                    n_state = ST_ACT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_ACT: begin
                o_cmd.act = 1'b1;
                n_state   = ST_DELIVER;
            end
            ST_DELIVER: begin
                // hold until the result slot is free or being emptied
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = o_cmd.load_out | (r_out_valid & i_out_stall);
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/dtor_dp.sv -----
// Datapath: divider, timer count, reload logic, register access and result register.
`timescale 1ns / 1ps
module dtor_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dtor_pkg::t_in         i_req,
    input  dtor_pkg::t_dp_cmd     i_cmd,
    output dtor_pkg::t_dp_status  o_status,
    output dtor_pkg::t_out        o_out
);
    import dtor_pkg::*;

    logic [15:0]       r_div, n_div;
    logic [7:0]        r_tima, n_tima;
    logic [7:0]        r_tma, n_tma;
    logic [2:0]        r_tac, n_tac;
    logic              r_last, n_last;
    logic [2:0]        r_delay, n_delay;
    logic              r_flag, n_flag;
    logic [STEP_W-1:0] r_steps, n_steps;
    logic              r_irq, n_irq;
    t_in               r_req;
    logic [7:0]        r_rd, n_rd;
    t_out              r_out;

    logic [CMP_W-1:0]  tick_ext;
    logic [CMP_W-1:0]  tick_sat;
    logic              gate;
    logic              new_last;

    always_comb begin
        n_div   = r_div;
        n_tima  = r_tima;
        n_tma   = r_tma;
        n_tac   = r_tac;
        n_last  = r_last;
        n_delay = r_delay;
        n_flag  = r_flag;
        n_steps = r_steps;
        n_irq   = r_irq;
        n_rd    = r_rd;
        gate     = 1'b0;
        new_last = 1'b0;

        // saturate the tick length at MAX_TICK_CYCLES and scale it to clock steps
        tick_ext = CMP_W'(i_req.tick_count);
        tick_sat = (tick_ext > CMP_W'(MAX_TICK_CYCLES)) ? CMP_W'(MAX_TICK_CYCLES) : tick_ext;

        if (i_cmd.capture) begin
            n_irq   = 1'b0;
            n_rd    = '0;
            n_steps = (i_req.func == FUNC_TICK) ? (STEP_W'(tick_sat) << 2) : '0;
        end

        if (i_cmd.step) begin
            n_steps = r_steps - STEP_W'(1);
            n_flag  = 1'b0;
            if (r_delay != 3'd0) begin
                n_delay = r_delay - 3'd1;
                if (n_delay == 3'd0) begin
                    n_irq  = 1'b1;
                    n_tima = r_tma;
                    n_flag = 1'b1;
                end
            end
            n_div = r_div + 16'd1;
            gate  = n_div[sel_bit(r_tac[1:0])] & r_tac[2];
            if (r_last && !gate) begin
                n_tima = n_tima + 8'd1;
                if (n_tima == 8'd0) begin
                    n_delay = RELOAD_DELAY;
                end
            end
            n_last = gate;
        end

        if (i_cmd.act) begin
            if (r_req.func == FUNC_READ) begin
                case (r_req.reg_select)
                    REG_DIV:  n_rd = r_div[15:8];
                    REG_TIMA: n_rd = r_tima;
                    REG_TMA:  n_rd = r_tma;
                    default:  n_rd = CTRL_READ_MASK | {5'd0, r_tac};
                endcase
            end else if (r_req.func == FUNC_WRITE) begin
                case (r_req.reg_select)
                    REG_DIV: begin
                        // cleared divider drops the gated bit
                        n_div  = '0;
                        n_last = 1'b0;
                        if (r_last) begin
                            n_tima = r_tima + 8'd1;
                            if (n_tima == 8'd0) begin
                                n_delay = RELOAD_DELAY;
                            end
                        end
                    end
                    REG_TIMA: begin
                        if (!r_flag) begin
                            n_tima = r_req.write_data;
                        end
                        // cancel a reload about to land
                        if (r_delay == 3'd1) begin
                            n_delay = 3'd0;
                        end
                    end
                    REG_TMA: begin
                        if (r_flag) begin
                            n_tima = r_req.write_data;
                        end
                        n_tma = r_req.write_data;
                    end
                    default: begin
                        new_last = r_last & r_req.write_data[2];
                        n_last   = new_last;
                        if (r_last && !new_last) begin
                            n_tima = r_tima + 8'd1;
                            if (n_tima == 8'd0) begin
                                n_delay = RELOAD_DELAY;
                            end
                        end
                        n_tac = r_req.write_data[2:0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div   <= DIV_RESET;
            r_tima  <= '0;
            r_tma   <= '0;
            r_tac   <= '0;
            r_last  <= 1'b0;
            r_delay <= '0;
            r_flag  <= 1'b0;
            r_steps <= '0;
            r_irq   <= 1'b0;
        end else begin
            r_div   <= n_div;
            r_tima  <= n_tima;
            r_tma   <= n_tma;
            r_tac   <= n_tac;
            r_last  <= n_last;
            r_delay <= n_delay;
            r_flag  <= n_flag;
            r_steps <= n_steps;
            r_irq   <= n_irq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= n_rd;
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.load_out) begin
            r_out.read_data <= r_rd;
            r_out.timer_irq <= r_irq;
        end
    end

    assign o_status.steps_zero = (r_steps == '0);
    assign o_out               = r_out;

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the divider timer block: directed and random requests against a timer model.
`timescale 1ns / 1ps
module tb;
    import dtor_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 4 * MAX_TICK_CYCLES + 20;
    localparam int RANDOM_ITEMS = 1680;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_in  i_in        = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out;

    // Local copy of the timer state
    logic [15:0] tmr_div;
    logic [7:0]  tmr_tima;
    logic [7:0]  tmr_tma;
    logic [2:0]  tmr_tac;
    logic        tmr_gate;
    logic [2:0]  tmr_delay;
    logic        tmr_reload_now;

    t_out pending_results[$];
    int   errors          = 0;
    int   requests_sent   = 0;
    int   results_checked = 0;
    int   irqs_seen       = 0;
    bit   quiet           = 1'b0;
    int   stall_pct       = 30;

    always #1 i_clk = ~i_clk;

    divider_timer_overflow_reload_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    function automatic logic gated_bit(input logic [15:0] d, input logic [2:0] tac);
        logic b;
        case (tac[1:0])
            2'd0:    b = d[9];
            2'd1:    b = d[3];
            2'd2:    b = d[5];
            default: b = d[7];
        endcase
        return b & tac[2];
    endfunction

    task automatic reset_timer_model();
        tmr_div        = DIV_RESET;
        tmr_tima       = 8'd0;
        tmr_tma        = 8'd0;
        tmr_tac        = 3'd0;
        tmr_gate       = 1'b0;
        tmr_delay      = 3'd0;
        tmr_reload_now = 1'b0;
    endtask

    // Count the timer on a falling edge of the gated bit; arm the reload on wrap
    task automatic update_gate(input logic g);
        if (tmr_gate && !g) begin
            tmr_tima = tmr_tima + 8'd1;
            if (tmr_tima == 8'd0)
                tmr_delay = RELOAD_DELAY;
        end
        tmr_gate = g;
    endtask

    task automatic advance_step(inout logic irq);
        tmr_reload_now = 1'b0;
        if (tmr_delay != 3'd0) begin
            tmr_delay = tmr_delay - 3'd1;
            if (tmr_delay == 3'd0) begin
                irq            = 1'b1;
                tmr_tima       = tmr_tma;
                tmr_reload_now = 1'b1;
            end
        end
        tmr_div = tmr_div + 16'd1;
        update_gate(gated_bit(tmr_div, tmr_tac));
    endtask

    task automatic predict_timer(input t_in req, output t_out res);
        int steps;
        res = '0;
        case (req.func)
            FUNC_TICK: begin
                steps = (req.tick_count > MAX_TICK_CYCLES) ? MAX_TICK_CYCLES : req.tick_count;
                repeat (4 * steps) advance_step(res.timer_irq);
            end
            FUNC_READ: begin
                case (req.reg_select)
                    REG_DIV:  res.read_data = tmr_div[15:8];
                    REG_TIMA: res.read_data = tmr_tima;
                    REG_TMA:  res.read_data = tmr_tma;
                    default:  res.read_data = CTRL_READ_MASK | {5'd0, tmr_tac};
                endcase
            end
            FUNC_WRITE: begin
                case (req.reg_select)
                    REG_DIV: begin
                        tmr_div = 16'd0;
                        update_gate(gated_bit(tmr_div, tmr_tac));
                    end
                    REG_TIMA: begin
                        // a write in the reload step loses to the reload
                        if (!tmr_reload_now)
                            tmr_tima = req.write_data;
                        if (tmr_delay == 3'd1)
                            tmr_delay = 3'd0;
                    end
                    REG_TMA: begin
                        if (tmr_reload_now)
                            tmr_tima = req.write_data;
                        tmr_tma = req.write_data;
                    end
                    default: begin
                        update_gate(tmr_gate & req.write_data[2]);
                        tmr_tac = req.write_data[2:0];
                    end
                endcase
            end
            default: ;
        endcase
    endtask

    // Mostly no gap, some short, a few long
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 15);
        else
            return $urandom_range(30, 120);
    endfunction

    task automatic send_request(input t_func f, input t_reg r, input logic [7:0] d,
                                input logic [3:0] n);
        int   gap;
        t_in  req;
        t_out res;
        gap = quiet ? 0 : random_gap();
        req = '{func: f, reg_select: r, write_data: d, tick_count: n};
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in       = req;
        do @(posedge i_clk); while (o_in_stall);
        predict_timer(req, res);
        pending_results.push_back(res);
        requests_sent++;
    endtask

    // Drop valid and hold until every request has its result
    task automatic wait_results_done();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reset_values();
        send_request(FUNC_READ, REG_DIV, 8'h00, 4'd0);
        send_request(FUNC_READ, REG_TIMA, 8'hFF, 4'd15);
        send_request(FUNC_READ, REG_TMA, 8'h00, 4'd0);
        send_request(FUNC_READ, REG_TAC, 8'hFF, 4'd15);
    endtask

    task automatic test_register_access();
        send_request(FUNC_WRITE, REG_TMA, 8'hFF, 4'd0);
        send_request(FUNC_READ, REG_TMA, 8'h00, 4'd0);
        send_request(FUNC_WRITE, REG_TAC, 8'hFF, 4'd15);
        send_request(FUNC_READ, REG_TAC, 8'h00, 4'd0);
        send_request(FUNC_WRITE, REG_TAC, 8'h00, 4'd0);
        send_request(FUNC_WRITE, REG_TIMA, 8'hAA, 4'd0);
        send_request(FUNC_READ, REG_TIMA, 8'h00, 4'd0);
    endtask

    task automatic test_overflow_reload();
        send_request(FUNC_WRITE, REG_TMA, 8'h80, 4'd0);
        send_request(FUNC_WRITE, REG_TAC, 8'h05, 4'd0);
        send_request(FUNC_WRITE, REG_DIV, 8'h77, 4'd0);
        send_request(FUNC_WRITE, REG_TIMA, 8'hFF, 4'd0);
        // wrap at the end of this tick, reload during the next one
        send_request(FUNC_TICK, REG_DIV, 8'h00, 4'd4);
        send_request(FUNC_TICK, REG_DIV, 8'h00, 4'd1);
        send_request(FUNC_WRITE, REG_TIMA, 8'h12, 4'd0);
        send_request(FUNC_WRITE, REG_TMA, 8'h34, 4'd0);
        send_request(FUNC_READ, REG_TIMA, 8'h00, 4'd0);
        send_request(FUNC_TICK, REG_DIV, 8'h00, 4'd15);
        send_request(FUNC_WRITE, REG_TAC, 8'h01, 4'd0);
    endtask

    task automatic test_special_requests();
        send_request(FUNC_TICK, REG_TAC, 8'hFF, 4'd0);
        send_request(FUNC_NONE, REG_TAC, 8'hFF, 4'd15);
        send_request(FUNC_WRITE, REG_DIV, 8'hFF, 4'd15);
        send_request(FUNC_READ, REG_DIV, 8'h00, 4'd0);
        wait_results_done();
    endtask

    task automatic test_random_traffic(input int count);
        int         sent;
        int         seq_len;
        int         pick;
        bit         paused;
        t_func      f;
        logic [7:0] d;
        logic [3:0] n;
        sent   = 0;
        paused = 1'b0;
        while (sent < count) begin
            if ($urandom_range(0, 19) == 0) begin
                quiet     = ($urandom_range(0, 3) == 0);
                stall_pct = $urandom_range(0, 60);
            end
            if (!paused && sent >= count / 2) begin
                wait_results_done();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 6) begin
                // arm the timer close to wrap, then run it with mixed traffic
                d      = 8'($urandom_range(0, 255));
                d[2]   = ($urandom_range(0, 9) != 0);
                d[1:0] = $urandom_range(0, 1) ? 2'd1 : 2'($urandom_range(0, 3));
                send_request(FUNC_WRITE, REG_TAC, d, 4'($urandom_range(0, 15)));
                send_request(FUNC_WRITE, REG_TIMA, 8'($urandom_range(8'hF8, 8'hFF)),
                             4'($urandom_range(0, 15)));
                sent += 2;
                seq_len = $urandom_range(3, 10);
                repeat (seq_len) begin
                    pick = $urandom_range(0, 99);
                    d    = 8'($urandom_range(0, 255));
                    if (pick < 50) begin
                        pick = $urandom_range(0, 9);
                        n = (pick < 7) ? 4'($urandom_range(1, 4)) :
                            (pick < 8) ? 4'd0 : 4'($urandom_range(5, 15));
                        send_request(FUNC_TICK, t_reg'($urandom_range(0, 3)), d, n);
                    end else if (pick < 70) begin
                        send_request(FUNC_READ, t_reg'($urandom_range(0, 3)), d,
                                     4'($urandom_range(0, 15)));
                    end else if (pick < 85) begin
                        if ($urandom_range(0, 1))
                            d = 8'hFF;
                        send_request(FUNC_WRITE, REG_TIMA, d, 4'($urandom_range(0, 15)));
                    end else if (pick < 95) begin
                        send_request(FUNC_WRITE, REG_TMA, d, 4'($urandom_range(0, 15)));
                    end else begin
                        send_request(FUNC_WRITE, REG_DIV, d, 4'($urandom_range(0, 15)));
                    end
                    sent++;
                end
            end else begin
                f = t_func'($urandom_range(0, 3));
                send_request(f, t_reg'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             4'($urandom_range(0, 15)));
                if (f != FUNC_NONE)
                    sent++;
            end
        end
        quiet = 1'b0;
    endtask

    // Receiver: stall in bursts of random length
    initial begin : out_stall_gen
        forever begin
            if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                i_out_stall = 1'b1;
                repeat (random_gap() + 1) @(negedge i_clk);
            end else begin
                i_out_stall = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request waiting: read_data %0h timer_irq %0b",
                       o_out.read_data, o_out.timer_irq);
                errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_out.read_data !== exp_res.read_data) begin
                    $error("read_data expected %0h actual %0h",
                           exp_res.read_data, o_out.read_data);
                    errors++;
                end
                if (o_out.timer_irq !== exp_res.timer_irq) begin
                    $error("timer_irq expected %0b actual %0b",
                           exp_res.timer_irq, o_out.timer_irq);
                    errors++;
                end
                results_checked++;
                if (exp_res.timer_irq)
                    irqs_seen++;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no request or result moved for %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        reset_timer_model();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_values();
        test_register_access();
        test_overflow_reload();
        test_special_requests();
        test_random_traffic(RANDOM_ITEMS);
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests, checked %0d results, %0d with the timer interrupt.",
                 requests_sent, results_checked, irqs_seen);
        $display("Ticks of 0 to 15 cycles, all register reads and writes, %s",
                 "wrap and reload, unused requests.");
        if (errors == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
